FILE: src/mstw_pkg.sv
// ----------------------------------------------------------------------------
// mstw_pkg
// Types, sizes and helpers for the minimum spanning tree weight block.
// ----------------------------------------------------------------------------
package mstw_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 1024;

    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int VCNT_W  = 11;
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int WGT_W   = 16;
    localparam int SUM_W   = 26;

    typedef struct packed {
        logic [9:0]        edge_from;
        logic [9:0]        edge_to;
        logic signed [15:0] edge_weight;
        logic              last_edge;
    } edge_beat_t;

    typedef struct packed {
        logic signed [25:0] tree_weight;
        logic [10:0]        sets_remaining;
    } result_beat_t;

    typedef struct packed {
        logic [9:0]         src_v;
        logic [9:0]         dst_v;
        logic signed [15:0] weight;
    } edge_entry_t;

    typedef struct packed {
        logic        valid;
        edge_entry_t entry;
    } cell_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } chain_ctrl_t;

    typedef struct packed {
        logic              start;
        logic              take;
        logic [ECNT_W-1:0] edge_count;
        logic [VCNT_W-1:0] verts;
    } uf_ctrl_t;

    typedef struct packed {
        logic pop;
        logic done;
    } uf_stat_t;

    localparam cell_t HEAD_GUARD = '{valid: 1'b1,
                                     entry: '{src_v: '0, dst_v: '0, weight: 16'sh8000}};
    localparam cell_t TAIL_GUARD = '{valid: 1'b0,
                                     entry: '{src_v: '0, dst_v: '0, weight: 16'sh7fff}};

    function automatic logic [VCNT_W-1:0] eff_verts(input logic [VCNT_W-1:0] vc);
        logic [VCNT_W-1:0] v;
        v = vc;
        if (vc == '0)
        begin
            v = VCNT_W'(1);
        end
        else if (vc > VCNT_W'(MAX_VERTICES))
        begin
            v = VCNT_W'(MAX_VERTICES);
        end
        return v;
    endfunction

endpackage

FILE: src/mstw_sort_cell.sv
// ----------------------------------------------------------------------------
// mstw_sort_cell
// One slot of the sorted edge chain: insert by weight, shift toward head.
// ----------------------------------------------------------------------------
module mstw_sort_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mstw_pkg::chain_ctrl_t ctrl,
    input  mstw_pkg::edge_entry_t new_entry,
    input  mstw_pkg::cell_t       left,
    input  mstw_pkg::cell_t       right,
    output mstw_pkg::cell_t       cell_out
);

    logic                  valid_reg;
    mstw_pkg::edge_entry_t entry_reg;
    logic                  keep;
    logic                  left_le;

    assign keep    = valid_reg && (entry_reg.weight <= new_entry.weight);
    assign left_le = left.valid && (left.entry.weight <= new_entry.weight);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.insert && !keep)
        begin
            valid_reg <= left_le ? 1'b1 : left.valid;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= right.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert && !keep)
        begin
            entry_reg <= left_le ? new_entry : left.entry;
        end
        else if (ctrl.shift && !ctrl.clear)
        begin
            entry_reg <= right.entry;
        end
    end

    assign cell_out = '{valid: valid_reg, entry: entry_reg};

endmodule

FILE: src/mstw_sort_chain.sv
// ----------------------------------------------------------------------------
// mstw_sort_chain
// Row of sort cells holding the edges in ascending weight, head at cell 0.
// ----------------------------------------------------------------------------
module mstw_sort_chain (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mstw_pkg::chain_ctrl_t ctrl,
    input  mstw_pkg::edge_entry_t new_entry,
    output mstw_pkg::edge_entry_t head
);

    mstw_pkg::cell_t cell_q [mstw_pkg::MAX_EDGES];

    genvar i;
    generate
        for (i = 0; i < mstw_pkg::MAX_EDGES; i++)
        begin : g_cell
            mstw_pkg::cell_t l_in;
            mstw_pkg::cell_t r_in;
            if (i == 0)
            begin : g_head
                assign l_in = mstw_pkg::HEAD_GUARD;
            end
            else
            begin : g_mid_l
                assign l_in = cell_q[i-1];
            end
            if (i == mstw_pkg::MAX_EDGES - 1)
            begin : g_tail
                assign r_in = mstw_pkg::TAIL_GUARD;
            end
            else
            begin : g_mid_r
                assign r_in = cell_q[i+1];
            end
            mstw_sort_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_entry (new_entry),
                .left      (l_in),
                .right     (r_in),
                .cell_out  (cell_q[i])
            );
        end
    endgenerate

    assign head = cell_q[0].entry;

endmodule

FILE: src/mstw_union_find.sv
// ----------------------------------------------------------------------------
// mstw_union_find
// Kruskal sequencer: parent store clear, root walks, merges and weight sum.
// ----------------------------------------------------------------------------
module mstw_union_find (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mstw_pkg::uf_ctrl_t       ctrl,
    input  mstw_pkg::edge_entry_t    head,
    output mstw_pkg::uf_stat_t       stat,
    output mstw_pkg::result_beat_t   result
);

    localparam int VW = mstw_pkg::VIDX_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_NEXT  = 7'b0000100,
        ST_FINDA = 7'b0001000,
        ST_FINDB = 7'b0010000,
        ST_SPARE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } uf_state_t;

    uf_state_t                     state_reg, state_next;
    logic [VW-1:0]                 parent_mem [mstw_pkg::MAX_VERTICES];
    logic [VW-1:0]                 rd_addr;
    logic [VW-1:0]                 rd_data_reg;
    logic [VW-1:0]                 x_reg;
    logic [VW-1:0]                 ra_reg;
    logic [VW-1:0]                 clr_reg;
    logic [mstw_pkg::ECNT_W-1:0]   left_reg;
    logic [mstw_pkg::VCNT_W-1:0]   sets_reg;
    logic [mstw_pkg::VCNT_W-1:0]   verts_reg;
    logic signed [mstw_pkg::SUM_W-1:0] sum_reg;
    mstw_pkg::edge_entry_t         cur_reg;
    logic                          wr_en;
    logic [VW-1:0]                 wr_addr;
    logic [VW-1:0]                 wr_data;
    logic                          root_hit;
    logic                          in_range;
    logic                          merge;

    assign root_hit = (rd_data_reg == x_reg);
    assign in_range = ({1'b0, head.src_v} < verts_reg) && ({1'b0, head.dst_v} < verts_reg);
    assign merge    = (state_reg == ST_FINDB) && root_hit && (ra_reg != x_reg);

    always_comb
    begin
        state_next = state_reg;
        rd_addr    = head.src_v;
        wr_en      = 1'b0;
        wr_addr    = clr_reg;
        wr_data    = clr_reg;
        stat.pop   = 1'b0;
        stat.done  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_reg == VW'(mstw_pkg::MAX_VERTICES - 1))
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (left_reg == '0 || sets_reg <= mstw_pkg::VCNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    stat.pop = 1'b1;
                    if (in_range)
                    begin
                        state_next = ST_FINDA;
                    end
                end
            end
            ST_FINDA:
            begin
                if (root_hit)
                begin
                    rd_addr    = cur_reg.dst_v;
                    state_next = ST_FINDB;
                end
                else
                begin
                    rd_addr = rd_data_reg;
                end
            end
            ST_FINDB:
            begin
                rd_addr = rd_data_reg;
                if (root_hit)
                begin
                    state_next = ST_NEXT;
                    if (ra_reg != x_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ra_reg;
                        wr_data = x_reg;
                    end
                end
            end
            ST_DONE:
            begin
                stat.done = 1'b1;
                if (ctrl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            parent_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= parent_mem[rd_addr];
        x_reg       <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clr_reg   <= '0;
            left_reg  <= '0;
            sets_reg  <= mstw_pkg::VCNT_W'(mstw_pkg::MAX_VERTICES);
            verts_reg <= mstw_pkg::VCNT_W'(mstw_pkg::MAX_VERTICES);
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && ctrl.start)
            begin
                clr_reg   <= '0;
                left_reg  <= ctrl.edge_count;
                sets_reg  <= ctrl.verts;
                verts_reg <= ctrl.verts;
                sum_reg   <= '0;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + VW'(1);
            end
            if (stat.pop)
            begin
                left_reg <= left_reg - mstw_pkg::ECNT_W'(1);
            end
            if (merge)
            begin
                sets_reg <= sets_reg - mstw_pkg::VCNT_W'(1);
                sum_reg  <= sum_reg + mstw_pkg::SUM_W'(cur_reg.weight);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.pop)
        begin
            cur_reg <= head;
        end
        if (state_reg == ST_FINDA && root_hit)
        begin
            ra_reg <= x_reg;
        end
    end

    assign result.tree_weight    = sum_reg;
    assign result.sets_remaining = sets_reg;

    a_pop_has_edge: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> (left_reg != '0))
        else $error("pop with no edge left");
    a_sets_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        merge |=> (sets_reg != '0))
        else $error("set count underflow");
    a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == ST_FINDB) |-> (wr_addr != wr_data))
        else $error("merge of a set with itself");

endmodule

FILE: src/minimum_spanning_tree_weight.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight
// Stores edges in a sorted cell chain, then runs Kruskal over a union-find.
// ----------------------------------------------------------------------------
// channel  direction  handshake            beat
// edge     in         edge_valid/stall     edge_beat_t
// result   out        result_valid/stall   result_beat_t
// cfg      in         cfg_valid/ready      vertex_count, 11 bits
//
// Edges load one per cycle into the sort chain (insertion at every cell)
// in the load state. After the last beat the parent store is cleared, then
// each edge is popped and, with both ends in range, both roots are found.
// No edges are taken from the last beat until the result is handed over.
// A result waits in its register under stall while loading goes on.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_weight (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   edge_valid,
    output logic                   edge_stall,
    input  mstw_pkg::edge_beat_t   edge_data,
    output logic                   result_valid,
    input  logic                   result_stall,
    output mstw_pkg::result_beat_t result_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [10:0]            cfg_data
);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_RUN  = 2'b10
    } top_state_t;

    top_state_t                  state_reg, state_next;
    logic [mstw_pkg::ECNT_W-1:0] count_reg;
    logic [mstw_pkg::VCNT_W-1:0] vc_reg;
    logic                        rv_reg;
    mstw_pkg::result_beat_t      rd_reg;
    logic                        accept;
    logic                        insert;
    mstw_pkg::chain_ctrl_t       chain_ctrl;
    mstw_pkg::edge_entry_t       new_entry;
    mstw_pkg::edge_entry_t       head;
    mstw_pkg::uf_ctrl_t          uf_ctrl;
    mstw_pkg::uf_stat_t          uf_stat;
    mstw_pkg::result_beat_t      uf_result;

    assign cfg_ready  = 1'b1;
    assign edge_stall = (state_reg != ST_LOAD);
    assign accept     = edge_valid && !edge_stall;
    assign insert     = accept && (count_reg != mstw_pkg::ECNT_W'(mstw_pkg::MAX_EDGES));

    assign new_entry = '{src_v: edge_data.edge_from, dst_v: edge_data.edge_to,
                         weight: edge_data.edge_weight};

    assign uf_ctrl.start      = accept && edge_data.last_edge;
    assign uf_ctrl.take       = uf_stat.done && (!rv_reg || !result_stall);
    assign uf_ctrl.edge_count = insert ? count_reg + mstw_pkg::ECNT_W'(1) : count_reg;
    assign uf_ctrl.verts      = mstw_pkg::eff_verts(vc_reg);

    assign chain_ctrl.insert = insert;
    assign chain_ctrl.shift  = uf_stat.pop;
    assign chain_ctrl.clear  = uf_ctrl.take;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (uf_ctrl.start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (uf_ctrl.take)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            vc_reg    <= mstw_pkg::VCNT_W'(mstw_pkg::MAX_VERTICES);
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                vc_reg <= cfg_data;
            end
            if (uf_ctrl.take)
            begin
                count_reg <= '0;
            end
            else if (insert)
            begin
                count_reg <= count_reg + mstw_pkg::ECNT_W'(1);
            end
            if (uf_ctrl.take)
            begin
                rv_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (uf_ctrl.take)
        begin
            rd_reg <= uf_result;
        end
    end

    assign result_valid = rv_reg;
    assign result_data  = rd_reg;

    mstw_sort_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (chain_ctrl),
        .new_entry (new_entry),
        .head      (head)
    );

    mstw_union_find u_uf (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (uf_ctrl),
        .head   (head),
        .stat   (uf_stat),
        .result (uf_result)
    );

endmodule

FILE: tb/sv/tb_minimum_spanning_tree_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_minimum_spanning_tree_weight
// Sends graphs as streams of edge beats. A local Kruskal model predicts the
// tree weight and the number of sets left for each graph, and the monitor
// checks each result beat against that prediction. Phases change the vertex
// count and the idle and stall rates.
// ----------------------------------------------------------------------------
module tb_minimum_spanning_tree_weight;

    logic                   clk;
    logic                   rst_n;
    logic                   edge_valid;
    logic                   edge_stall;
    mstw_pkg::edge_beat_t   edge_data;
    logic                   result_valid;
    logic                   result_stall;
    mstw_pkg::result_beat_t result_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [10:0]            cfg_data;

    minimum_spanning_tree_weight i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_stall   (edge_stall),
        .edge_data    (edge_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    mstw_pkg::edge_beat_t   pending_edges[$];
    mstw_pkg::result_beat_t expected_trees[$];

    mstw_pkg::edge_entry_t graph_edges[mstw_pkg::MAX_EDGES];
    int unsigned           graph_size;
    logic [9:0]            forest[mstw_pkg::MAX_VERTICES];
    logic [10:0]           vertex_count;
    int                    send_idle_pct;
    int                    stall_pct;
    bit                    beat_pending;
    int                    errors;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int unsigned live_vertices();
        int unsigned v;
        v = vertex_count;
        if (v == 0)
        begin
            v = 1;
        end
        if (v > mstw_pkg::MAX_VERTICES)
        begin
            v = mstw_pkg::MAX_VERTICES;
        end
        return v;
    endfunction

    function automatic logic [9:0] root_of(input logic [9:0] x);
        int steps;
        steps = 0;
        while (forest[x] != x && steps < mstw_pkg::MAX_VERTICES)
        begin
            x = forest[x];
            steps++;
        end
        return x;
    endfunction

    function automatic mstw_pkg::result_beat_t span_forest();
        mstw_pkg::result_beat_t res;
        mstw_pkg::edge_entry_t  cur;
        int unsigned  verts;
        int unsigned  sets;
        int           j;
        logic [9:0]   ra;
        logic [9:0]   rb;
        logic signed [25:0] total;
        verts = live_vertices();
        for (int i = 0; i < mstw_pkg::MAX_VERTICES; i++)
        begin
            forest[i] = 10'(i);
        end
        for (int i = 1; i < graph_size; i++)
        begin
            cur = graph_edges[i];
            j = i;
            while (j > 0 && graph_edges[j-1].weight > cur.weight)
            begin
                graph_edges[j] = graph_edges[j-1];
                j--;
            end
            graph_edges[j] = cur;
        end
        sets  = verts;
        total = '0;
        for (int i = 0; i < graph_size && sets > 1; i++)
        begin
            if (graph_edges[i].src_v < verts && graph_edges[i].dst_v < verts)
            begin
                ra = root_of(graph_edges[i].src_v);
                rb = root_of(graph_edges[i].dst_v);
                if (ra != rb)
                begin
                    forest[ra] = rb;
                    sets--;
                    total = total + 26'(graph_edges[i].weight);
                end
            end
        end
        res.tree_weight    = total;
        res.sets_remaining = 11'(sets);
        return res;
    endfunction

    function automatic void take_edge(input mstw_pkg::edge_beat_t e);
        if (graph_size < mstw_pkg::MAX_EDGES)
        begin
            graph_edges[graph_size].src_v  = e.edge_from;
            graph_edges[graph_size].dst_v  = e.edge_to;
            graph_edges[graph_size].weight = e.edge_weight;
            graph_size++;
        end
        if (e.last_edge)
        begin
            expected_trees.push_back(span_forest());
            graph_size = 0;
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (edge_valid && !edge_stall)
        begin
            take_edge(edge_data);
            beat_pending = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !beat_pending)
        begin
            if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                edge_data    <= pending_edges.pop_front();
                edge_valid   <= 1'b1;
                beat_pending = 1'b1;
            end
            else
            begin
                edge_valid <= 1'b0;
            end
        end
        result_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        mstw_pkg::result_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_trees.size() == 0)
            begin
                $display("%0t: unexpected result tree_weight=%0d sets_remaining=%0d",
                         $time, result_data.tree_weight, result_data.sets_remaining);
                errors++;
            end
            else
            begin
                want = expected_trees.pop_front();
                if (result_data.tree_weight !== want.tree_weight)
                begin
                    $display("%0t: tree_weight expected %0d actual %0d",
                             $time, want.tree_weight, result_data.tree_weight);
                    errors++;
                end
                if (result_data.sets_remaining !== want.sets_remaining)
                begin
                    $display("%0t: sets_remaining expected %0d actual %0d",
                             $time, want.sets_remaining, result_data.sets_remaining);
                    errors++;
                end
            end
        end
    end

    task automatic push_edge(input int f, input int t, input int w, input bit last);
        mstw_pkg::edge_beat_t e;
        e.edge_from   = 10'(f);
        e.edge_to     = 10'(t);
        e.edge_weight = 16'(w);
        e.last_edge   = last;
        pending_edges.push_back(e);
    endtask

    task automatic push_graph(input int n);
        int unsigned verts;
        int          f;
        int          t;
        int          w;
        verts = live_vertices();
        for (int i = 0; i < n; i++)
        begin
            f = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(verts - 1);
            t = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(verts - 1);
            w = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(20) - 10;
            push_edge(f, t, w, i == n - 1);
        end
    endtask

    task automatic drain();
        while (pending_edges.size() > 0 || beat_pending || expected_trees.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
    endtask

    task automatic set_vertex_count(input logic [10:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        vertex_count = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [10:0] v, input int idle, input int stall,
                                input int items);
        int sent;
        int n;
        drain();
        set_vertex_count(v);
        send_idle_pct = idle;
        stall_pct     = stall;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
            push_graph(n);
            sent += n;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        edge_valid    = 1'b0;
        edge_data     = '0;
        result_stall  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        vertex_count  = 11'd1024;
        graph_size    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        beat_pending  = 1'b0;
        errors        = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset vertex count, extremes of every field
        push_edge(0, 1023, -32768, 0);
        push_edge(1023, 0, 32767, 0);
        push_edge(5, 5, 100, 0);
        push_edge(1, 2, 7, 1);
        push_edge(0, 0, 0, 1);
        drain();

        // four vertices: out of range endpoints, self loops, ties
        set_vertex_count(11'd4);
        push_edge(0, 1, 3, 0);
        push_edge(1, 2, -5, 0);
        push_edge(2, 3, 2, 0);
        push_edge(3, 0, -9, 0);
        push_edge(0, 4, -100, 0);
        push_edge(1023, 2, -200, 1);
        push_edge(0, 1, 5, 0);
        push_edge(1, 2, 5, 0);
        push_edge(0, 2, 5, 0);
        push_edge(3, 3, -1, 1);
        drain();

        set_vertex_count(11'd0);
        push_edge(0, 0, 1, 0);
        push_edge(0, 1, 9, 1);
        drain();

        set_vertex_count(11'd2047);
        push_edge(1023, 1022, -32768, 0);
        push_edge(512, 1023, 32767, 1);
        drain();

        // store overflow, last flag on a dropped edge
        set_vertex_count(11'd1024);
        push_graph(1030);

        random_phase(11'd16, 0, 0, 30);
        random_phase(11'd2, 80, 0, 20);
        random_phase(11'd8, 0, 80, 25);
        random_phase(11'd1, 32, 32, 20);
        random_phase(11'd1024, 80, 0, 20);
        random_phase(11'(512 + $urandom_range(511)), 0, 80, 20);
        random_phase(11'd5, 32, 32, 25);
        random_phase(11'(1 + $urandom_range(63)), 0, 0, 20);
        random_phase(11'd0, 0, 0, 20);
        drain();

        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
